>>> hw/rtl/frg_pkg.sv
package frg_pkg;

    localparam int FIELD_BITS    = 32;
    localparam int STATUS_BITS   = 2;
    localparam int IN_DATA_BITS  = 64;
    localparam int OUT_USED_BITS = 3 * FIELD_BITS + STATUS_BITS;
    localparam int OUT_DATA_BITS = 104;
    localparam int OUT_PAD_BITS  = OUT_DATA_BITS - OUT_USED_BITS;

    // result status codes
    localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EUC_GO,
        S_EUC_WAIT,
        S_NUM_GO,
        S_NUM_WAIT,
        S_DEN_GO,
        S_DEN_WAIT,
        S_OUT
    } t_state;

    // status of the serial divider towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> hw/rtl/fraction_reduce_gcd.sv
// Channel   | Direction | Payload (lowest bit first)
// ----------+-----------+-----------------------------------------------------
// s_axis    | in        | numerator_in[31:0], denominator_in[63:32]
// m_axis    | out       | numerator_out, denominator_out, divisor, status, pad
//
// One request runs through a bit-serial restoring divider, one quotient bit per cycle while it is
// busy: Euclid's loop takes one division per step (up to about 46 at 32 bits), and two more
// divisions give the reduced pair; a zero denominator skips the divider and goes straight to
// S_OUT.
// Reset is synchronous and active low; it clears the sequencer and the output valid.
// The next request is taken once the result sits in the output register; a stall holds S_OUT.
module fraction_reduce_gcd #(
    parameter int WORD_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // numerator_in [31:0], denominator_in [63:32]
    input  logic [frg_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // numerator_out [31:0], denominator_out [63:32], divisor [95:64],
    // status [97:96], zero pad [103:98]
    output logic [frg_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata
);
    import frg_pkg::*;

    localparam logic [WORD_BITS-1:0] MINV = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [WORD_BITS-1:0] ONE  = WORD_BITS'(1);

    // Sign-extend a 32-bit field, then keep the working word.
    function automatic logic [WORD_BITS-1:0] from_field(input logic [FIELD_BITS-1:0] f);
        logic signed [63:0] e;
        begin
            e = 64'(signed'(f));
            return e[WORD_BITS-1:0];
        end
    endfunction

    // Sign-extend the working word, then keep the 32-bit field.
    function automatic logic [FIELD_BITS-1:0] to_field(input logic [WORD_BITS-1:0] x);
        logic signed [63:0] e;
        begin
            e = 64'(signed'(x));
            return e[FIELD_BITS-1:0];
        end
    endfunction

    // Magnitude of a signed word; the most negative value maps to 2^(W-1).
    function automatic logic [WORD_BITS-1:0] mag(input logic [WORD_BITS-1:0] x);
        return x[WORD_BITS-1] ? WORD_BITS'(-x) : x;
    endfunction

    t_state r_state, n_state;

    logic [WORD_BITS-1:0]   r_num, r_den;      // operands as taken in
    logic [WORD_BITS-1:0]   r_a, r_b;          // Euclid pair, magnitudes
    logic                   r_pa;              // index parity of the value in r_a
    logic                   r_gsign;           // sign of the divisor
    logic [WORD_BITS-1:0]   r_res_n, r_res_d, r_res_g;
    logic [STATUS_BITS-1:0] r_status;
    logic                   r_out_valid;
    logic [OUT_DATA_BITS-1:0] r_out_data;

    logic [WORD_BITS-1:0] w_num_in, w_den_in;
    logic                 w_accept;
    logic                 w_num_neg, w_den_neg;
    logic                 w_div_start;
    logic [WORD_BITS-1:0] w_dividend, w_divisor;
    logic [WORD_BITS-1:0] w_quo, w_rem;
    t_div_stat            w_div_stat;
    logic                 w_q_neg;
    logic [WORD_BITS-1:0] w_q_signed;
    logic [WORD_BITS-1:0] w_g_signed;
    logic                 w_out_load;

    assign w_num_in  = from_field(s_axis_tdata[FIELD_BITS-1:0]);
    assign w_den_in  = from_field(s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS]);
    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_num_neg = r_num[WORD_BITS-1];
    assign w_den_neg = r_den[WORD_BITS-1];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_out_load    = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    // Steer the shared divider: remainder steps first, then both quotients.
    always_comb begin
        unique case (r_state) inside
            S_NUM_GO, S_NUM_WAIT: begin
                w_dividend = mag(r_num);
                w_divisor  = r_a;
            end
            S_DEN_GO, S_DEN_WAIT: begin
                w_dividend = mag(r_den);
                w_divisor  = r_a;
            end
            default: begin
                w_dividend = r_a;
                w_divisor  = r_b;
            end
        endcase
    end

    assign w_div_start = (r_state == S_EUC_GO) || (r_state == S_NUM_GO) ||
                         (r_state == S_DEN_GO);

    frg_divu #(
        .WORD_BITS (WORD_BITS)
    ) u_divu (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_quotient  (w_quo),
        .o_remainder (w_rem),
        .o_stat      (w_div_stat)
    );

    // Truncating quotient: negate when operand and divisor signs differ.
    // The most negative by minus one wraps back to itself here.
    assign w_q_neg    = ((r_state == S_DEN_WAIT) ? w_den_neg : w_num_neg) ^ r_gsign;
    assign w_q_signed = w_q_neg ? WORD_BITS'(-w_quo) : w_quo;
    assign w_g_signed = r_gsign ? WORD_BITS'(-r_a) : r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (w_den_in == '0) ? S_OUT : S_EUC_GO;
                end
            end
            S_EUC_GO: n_state = S_EUC_WAIT;
            S_EUC_WAIT: begin
                if (w_div_stat.done) begin
                    n_state = (w_rem == '0) ? S_NUM_GO : S_EUC_GO;
                end
            end
            S_NUM_GO: n_state = S_NUM_WAIT;
            S_NUM_WAIT: begin
                if (w_div_stat.done) begin
                    n_state = S_DEN_GO;
                end
            end
            S_DEN_GO: n_state = S_DEN_WAIT;
            S_DEN_WAIT: begin
                if (w_div_stat.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Working registers. Remainders carry the dividend's sign, so the value
    // at an even index of the Euclid sequence has the numerator's sign and
    // the one at an odd index the denominator's; only magnitudes are iterated.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_num <= w_num_in;
                    r_den <= w_den_in;
                    r_a   <= mag(w_num_in);
                    r_b   <= mag(w_den_in);
                    r_pa  <= 1'b0;
                    // zero denominator: flag it and drop straight to output
                    r_res_n  <= '0;
                    r_res_d  <= '0;
                    r_res_g  <= '0;
                    r_status <= ST_ZERO_DEN;
                end
            end
            S_EUC_WAIT: begin
                if (w_div_stat.done) begin
                    // advance the pair; once the remainder is zero r_a holds g
                    r_a  <= r_b;
                    r_b  <= w_rem;
                    r_pa <= ~r_pa;
                    r_gsign <= r_pa ? w_num_neg : w_den_neg;
                end
            end
            S_NUM_WAIT: begin
                if (w_div_stat.done) begin
                    r_res_n <= w_q_signed;
                end
            end
            S_DEN_WAIT: begin
                if (w_div_stat.done) begin
                    r_res_d <= w_q_signed;
                    r_res_g <= w_g_signed;
                    r_status <= (r_gsign && (r_a == ONE) && ((r_num == MINV) || (r_den == MINV)))
                                ? ST_OVERFLOW : ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: hold the result until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {{OUT_PAD_BITS{1'b0}}, r_status, to_field(r_res_g),
                           to_field(r_res_d), to_field(r_res_n)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // The divider is idle whenever a new request may enter.
    a_ready_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_div_stat.busy)
        else $error("request taken while divider busy");

    // Divider completion is only seen while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_EUC_WAIT || r_state == S_NUM_WAIT ||
                             r_state == S_DEN_WAIT))
        else $error("divider done outside a wait state");

    // A zero denominator goes straight to the output with its status.
    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_den_in == '0) |=> (r_state == S_OUT && r_status == ST_ZERO_DEN))
        else $error("zero denominator not flagged");

endmodule

>>> hw/rtl/frg_divu.sv
module frg_divu #(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_BITS-1:0] i_dividend,
    input  logic [WORD_BITS-1:0] i_divisor,
    output logic [WORD_BITS-1:0] o_quotient,
    output logic [WORD_BITS-1:0] o_remainder,
    output frg_pkg::t_div_stat   o_stat
);
    import frg_pkg::*;

    localparam int CW = $clog2(WORD_BITS + 1);

    logic                 r_busy;
    logic [CW-1:0]        r_cnt;
    logic [WORD_BITS-1:0] r_rem;
    logic [WORD_BITS-1:0] r_quo;
    logic [WORD_BITS-1:0] r_dvs;

    logic [WORD_BITS:0]   w_trial;
    logic                 w_fit;
    logic [WORD_BITS-1:0] n_rem;
    logic [WORD_BITS-1:0] n_quo;

    // restoring step: bring down one dividend bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_quo[WORD_BITS-1]};
        w_fit   = (w_trial >= {1'b0, r_dvs});
        n_rem   = w_fit ? WORD_BITS'(w_trial - {1'b0, r_dvs}) : w_trial[WORD_BITS-1:0];
        n_quo   = {r_quo[WORD_BITS-2:0], w_fit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start && !r_busy) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(WORD_BITS);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy && r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && (r_cnt == '0);

endmodule
